// ===== rtl/wsp_pkg.sv =====
package wsp_pkg;

    // Parser phase
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_FMT_SKIP,
        PH_CHUNK_HDR,
        PH_CHUNK_SKIP,
        PH_DATA,
        PH_IDLE
    } phase_t;

    // Status report codes
    typedef enum logic [1:0] {
        ST_OPENED      = 2'd0,
        ST_INVALID     = 2'd1,
        ST_UNSUPPORTED = 2'd2
    } status_t;

    // Result kind
    localparam logic KIND_PCM    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Little-endian chunk signatures as they sit in the tag shifter
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Byte positions in the canonical header
    localparam logic [5:0] IDX_RIFF_END   = 6'd3;
    localparam logic [5:0] IDX_WAVE_END   = 6'd11;
    localparam logic [5:0] IDX_FMT_END    = 6'd15;
    localparam logic [5:0] IDX_FMT_LEN    = 6'd19;
    localparam logic [5:0] IDX_FORMAT     = 6'd21;
    localparam logic [5:0] IDX_CHANNELS   = 6'd23;
    localparam logic [5:0] IDX_RATE       = 6'd27;
    localparam logic [5:0] IDX_BITS       = 6'd35;

    // Byte positions in a chunk header
    localparam logic [5:0] IDX_TAG_BYTES  = 6'd4;
    localparam logic [5:0] IDX_CHUNK_LAST = 6'd7;

    localparam logic [31:0] FMT_BASE_LEN = 32'd16;
    localparam logic [15:0] FMT_PCM      = 16'd1;
    localparam logic [15:0] FMT_FLOAT    = 16'd3;
    localparam logic [15:0] FLOAT_BITS   = 16'd32;

    // One incoming byte with its markers
    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_byte;
        logic       end_of_file;
    } item_t;

    // One result item
    typedef struct packed {
        logic        kind;
        logic [7:0]  pcm_byte;
        status_t     status;
        logic [15:0] channel_count;
        logic [31:0] rate_hz;
        logic [15:0] sample_bits;
        logic [15:0] format_code;
        logic [31:0] data_length;
        logic        last_data;
    } result_t;

endpackage

// ===== rtl/wsp_parser.sv =====
module wsp_parser
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_valid,
    input  wsp_pkg::item_t   item,
    output logic             res_valid,
    output wsp_pkg::result_t res
);

    import wsp_pkg::*;

    phase_t      phase_reg, phase_next, phase_step;
    logic [5:0]  byte_index_reg, byte_index_next;
    logic [31:0] skip_count_reg, skip_count_next;
    logic [31:0] chunk_tag_reg, chunk_tag_next;
    logic [31:0] chunk_length_reg, chunk_length_next;
    logic [31:0] data_remaining_reg, data_remaining_next;
    logic [31:0] fmt_length_reg, fmt_length_next;
    logic [15:0] held_channels_reg, held_channels_next;
    logic [31:0] held_rate_reg, held_rate_next;
    logic [15:0] held_bits_reg, held_bits_next;
    logic [15:0] held_format_reg, held_format_next;

    // State as seen by this byte: a first byte restarts from the reset values
    phase_t      cur_phase;
    logic [5:0]  cur_idx;
    logic [31:0] cur_skip;
    logic [31:0] cur_tag;
    logic [31:0] cur_len;
    logic [31:0] cur_rem;
    logic [31:0] cur_fmt_len;
    logic [15:0] cur_channels;
    logic [31:0] cur_rate;
    logic [15:0] cur_format;
    logic [15:0] cur_bits;

    logic        restart;
    logic [31:0] tag_shift;
    logic [31:0] len_shift;
    logic [31:0] skip_dec;
    logic [31:0] rem_dec;
    logic        bad_sig;
    logic        fmt_ok;
    logic        chunk_done;

    assign restart      = item.first_byte;
    assign cur_phase    = restart ? PH_HEADER : phase_reg;
    assign cur_idx      = restart ? '0 : byte_index_reg;
    assign cur_skip     = restart ? '0 : skip_count_reg;
    assign cur_tag      = restart ? '0 : chunk_tag_reg;
    assign cur_len      = restart ? '0 : chunk_length_reg;
    assign cur_rem      = restart ? '0 : data_remaining_reg;
    assign cur_fmt_len  = restart ? '0 : fmt_length_reg;
    assign cur_channels = restart ? '0 : held_channels_reg;
    assign cur_rate     = restart ? '0 : held_rate_reg;
    assign cur_format   = restart ? '0 : held_format_reg;
    assign cur_bits     = restart ? '0 : held_bits_reg;

    // Shift the byte in from the top, little-endian
    assign tag_shift = {item.in_byte, cur_tag[31:8]};
    assign len_shift = {item.in_byte, cur_len[31:8]};
    assign skip_dec  = cur_skip - 32'd1;
    assign rem_dec   = cur_rem - 32'd1;

    assign bad_sig = (cur_idx == IDX_RIFF_END && tag_shift != TAG_RIFF) ||
                     (cur_idx == IDX_WAVE_END && tag_shift != TAG_WAVE) ||
                     (cur_idx == IDX_FMT_END  && tag_shift != TAG_FMT);

    assign fmt_ok = (cur_format == FMT_PCM) ||
                    (cur_format == FMT_FLOAT && tag_shift[31:16] == FLOAT_BITS);

    assign chunk_done = (cur_idx >= IDX_CHUNK_LAST);

    // Next state
    always_comb
    begin
        phase_step          = cur_phase;
        byte_index_next     = cur_idx;
        skip_count_next     = cur_skip;
        chunk_tag_next      = cur_tag;
        chunk_length_next   = cur_len;
        data_remaining_next = cur_rem;
        fmt_length_next     = cur_fmt_len;
        held_channels_next  = cur_channels;
        held_rate_next      = cur_rate;
        held_bits_next      = cur_bits;
        held_format_next    = cur_format;

        case (cur_phase)
            PH_HEADER:
            begin
                chunk_tag_next  = tag_shift;
                byte_index_next = cur_idx + 6'd1;
                if (bad_sig)
                begin
                    phase_step = PH_IDLE;
                end
                else
                begin
                    if (cur_idx == IDX_FMT_LEN)  fmt_length_next    = tag_shift;
                    if (cur_idx == IDX_FORMAT)   held_format_next   = tag_shift[31:16];
                    if (cur_idx == IDX_CHANNELS) held_channels_next = tag_shift[31:16];
                    if (cur_idx == IDX_RATE)     held_rate_next     = tag_shift;
                    if (cur_idx == IDX_BITS)
                    begin
                        held_bits_next = tag_shift[31:16];
                        if (!fmt_ok)
                        begin
                            phase_step = PH_IDLE;
                        end
                        else
                        begin
                            byte_index_next = '0;
                            if (cur_fmt_len > FMT_BASE_LEN)
                            begin
                                skip_count_next = cur_fmt_len - FMT_BASE_LEN;
                                phase_step      = PH_FMT_SKIP;
                            end
                            else
                            begin
                                phase_step = PH_CHUNK_HDR;
                            end
                        end
                    end
                end
            end
            PH_FMT_SKIP, PH_CHUNK_SKIP:
            begin
                skip_count_next = skip_dec;
                if (skip_dec == '0)
                begin
                    phase_step      = PH_CHUNK_HDR;
                    byte_index_next = '0;
                end
            end
            PH_CHUNK_HDR:
            begin
                byte_index_next = cur_idx + 6'd1;
                if (cur_idx < IDX_TAG_BYTES)
                begin
                    chunk_tag_next = tag_shift;
                end
                else
                begin
                    chunk_length_next = len_shift;
                    if (chunk_done)
                    begin
                        byte_index_next = '0;
                        if (cur_tag == TAG_DATA)
                        begin
                            data_remaining_next = len_shift;
                            phase_step          = PH_DATA;
                        end
                        else if (len_shift != '0)
                        begin
                            skip_count_next = len_shift;
                            phase_step      = PH_CHUNK_SKIP;
                        end
                    end
                end
            end
            PH_DATA:
            begin
                if (cur_rem == '0)
                begin
                    phase_step = PH_IDLE;
                end
                else
                begin
                    data_remaining_next = rem_dec;
                    if (rem_dec == '0)
                        phase_step = PH_IDLE;
                end
            end
            default:
            begin
                phase_step = PH_IDLE;
            end
        endcase

        // End of file always ends parsing
        phase_next = item.end_of_file ? PH_IDLE : phase_step;
    end

    // Result for this byte
    always_comb
    begin
        res       = '0;
        res_valid = 1'b0;

        case (cur_phase)
            PH_HEADER:
            begin
                if (bad_sig)
                begin
                    res_valid  = 1'b1;
                    res.kind   = KIND_STATUS;
                    res.status = ST_INVALID;
                end
                else if (cur_idx == IDX_BITS && !fmt_ok)
                begin
                    res_valid         = 1'b1;
                    res.kind          = KIND_STATUS;
                    res.status        = ST_UNSUPPORTED;
                    res.channel_count = cur_channels;
                    res.rate_hz       = cur_rate;
                    res.sample_bits   = tag_shift[31:16];
                    res.format_code   = cur_format;
                end
            end
            PH_CHUNK_HDR:
            begin
                if (cur_idx >= IDX_TAG_BYTES && chunk_done && cur_tag == TAG_DATA)
                begin
                    res_valid         = 1'b1;
                    res.kind          = KIND_STATUS;
                    res.status        = ST_OPENED;
                    res.channel_count = cur_channels;
                    res.rate_hz       = cur_rate;
                    res.sample_bits   = cur_bits;
                    res.format_code   = cur_format;
                    res.data_length   = len_shift;
                end
            end
            PH_DATA:
            begin
                if (cur_rem != '0)
                begin
                    res_valid     = 1'b1;
                    res.kind      = KIND_PCM;
                    res.pcm_byte  = item.in_byte;
                    res.last_data = (rem_dec == '0) || item.end_of_file;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase

        // Flag a file that ends before the data chunk opens
        if (item.end_of_file && !res_valid &&
            phase_step != PH_IDLE && phase_step != PH_DATA)
        begin
            res        = '0;
            res_valid  = 1'b1;
            res.kind   = KIND_STATUS;
            res.status = ST_INVALID;
        end

        res_valid = res_valid && step_valid;
    end

    // Advance parser state once per processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HEADER;
            byte_index_reg     <= '0;
            skip_count_reg     <= '0;
            chunk_tag_reg      <= '0;
            chunk_length_reg   <= '0;
            data_remaining_reg <= '0;
            fmt_length_reg     <= '0;
            held_channels_reg  <= '0;
            held_rate_reg      <= '0;
            held_bits_reg      <= '0;
            held_format_reg    <= '0;
        end
        else if (step_valid)
        begin
            phase_reg          <= phase_next;
            byte_index_reg     <= byte_index_next;
            skip_count_reg     <= skip_count_next;
            chunk_tag_reg      <= chunk_tag_next;
            chunk_length_reg   <= chunk_length_next;
            data_remaining_reg <= data_remaining_next;
            fmt_length_reg     <= fmt_length_next;
            held_channels_reg  <= held_channels_next;
            held_rate_reg      <= held_rate_next;
            held_bits_reg      <= held_bits_next;
            held_format_reg    <= held_format_next;
        end
    end

    // An idle parser stays silent until a new file starts
    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        step_valid && phase_reg == PH_IDLE && !item.first_byte |-> !res_valid)
        else $error("result produced while idle");

    // End of file leaves the parser idle
    a_eof_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step_valid && item.end_of_file |=> phase_reg == PH_IDLE)
        else $error("parser not idle after end of file");

    // An opened report hands over to the data phase
    a_open_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == KIND_STATUS && res.status == ST_OPENED &&
        !item.end_of_file |=> phase_reg == PH_DATA)
        else $error("opened report without data phase");

endmodule

// ===== rtl/wav_stream_header_parser_top.sv =====
// Channel   Dir  tdata                          tuser             tlast
// s_axis    in   [7:0] in_byte                  [0] first_byte    end_of_file
// m_axis    out  pcm_byte, status, header       [0] kind          last_data
//                fields, data_length (122 bits
//                packed, zero-filled to 128)
//
// One byte is taken every cycle while m_axis does not stall; each byte goes from the input
// register through the single-pass byte parser into the result register, from which m_axis
// takes its result (input register, single-pass byte parser, result register).
// rst_n clears both valid flags and the parser to its header phase.
// A stall on m_axis holds the result and lets one more byte wait in the
// input register before s_tready falls.
module wav_stream_header_parser_top
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] in_byte
    input  logic [0:0]   s_tuser,   // [0] first_byte
    input  logic         s_tlast,   // end_of_file

    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] pcm_byte, [9:8] status, [25:10] channel_count, [57:26] rate_hz,
    // [73:58] sample_bits, [89:74] format_code, [121:90] data_length, [127:122] zero
    output logic [127:0] m_tdata,
    output logic [0:0]   m_tuser,   // [0] kind
    output logic         m_tlast    // last_data
);

    import wsp_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;

    logic    advance;
    logic    s_fire;
    logic    res_valid;
    result_t res;

    // Move the held byte through the parser when the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    wsp_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (advance),
        .item       (in_item_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Input register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_fire)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    // Capture the incoming transaction
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_item_reg.in_byte     <= s_tdata;
            in_item_reg.first_byte  <= s_tuser[0];
            in_item_reg.end_of_file <= s_tlast;
        end
    end

    // Result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res_valid;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= res;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tuser[0] = out_res_reg.kind;
    assign m_tlast    = out_res_reg.last_data;
    assign m_tdata    = {6'd0,
                         out_res_reg.data_length,
                         out_res_reg.format_code,
                         out_res_reg.sample_bits,
                         out_res_reg.rate_hz,
                         out_res_reg.channel_count,
                         out_res_reg.status,
                         out_res_reg.pcm_byte};

endmodule

// ===== tb/sv/tb_wav_stream_header_parser_top.sv =====
module tb_wav_stream_header_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wsp_pkg::*;

    localparam int unsigned BYTE_TARGET    = 2000;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned SETTLE_CYCLES  = 20;
    localparam int unsigned MAX_GAP        = 13;

    // Chunk tags that the parser has to skip
    localparam logic [31:0] TAG_LIST = 32'h5453_494C;
    localparam logic [31:0] TAG_JUNK = 32'h6B6E_756A;

    // Track the parser state and hold the results it still owes
    class wav_parse_scoreboard;
        result_t     due_results[$];
        int unsigned error_count;
        int unsigned result_count;
        phase_t      parse_phase;
        logic [5:0]  byte_idx;
        logic [31:0] skip_left;
        logic [31:0] tag_shift;
        logic [31:0] chunk_len;
        logic [31:0] data_left;
        logic [31:0] fmt_len;
        logic [31:0] rate;
        logic [15:0] channels;
        logic [15:0] bits;
        logic [15:0] fmt_code;

        function new();
            error_count  = 0;
            result_count = 0;
            restart();
        endfunction

        function void restart();
            parse_phase = PH_HEADER;
            byte_idx    = '0;
            skip_left   = '0;
            tag_shift   = '0;
            chunk_len   = '0;
            data_left   = '0;
            fmt_len     = '0;
            rate        = '0;
            channels    = '0;
            bits        = '0;
            fmt_code    = '0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // Build a status report; every report ends the parse but an opened one, whose caller moves on to the data phase
        function result_t status_result(status_t st);
            result_t r;
            r        = '0;
            r.kind   = KIND_STATUS;
            r.status = st;
            if (st != ST_INVALID)
            begin
                r.channel_count = channels;
                r.rate_hz       = rate;
                r.sample_bits   = bits;
                r.format_code   = fmt_code;
            end
            if (st == ST_OPENED)
                r.data_length = data_left;
            parse_phase = PH_IDLE;
            return r;
        endfunction

        // Advance the parser by one accepted byte
        function void note_byte(item_t it);
            result_t    r;
            bit         made;
            logic [5:0] idx;
            made = 1'b0;
            r    = '0;
            if (it.first_byte)
                restart();
            case (parse_phase)
                PH_HEADER:
                begin
                    idx       = byte_idx;
                    tag_shift = {it.in_byte, tag_shift[31:8]};
                    byte_idx  = byte_idx + 6'd1;
                    if ((idx == IDX_RIFF_END && tag_shift != TAG_RIFF) ||
                        (idx == IDX_WAVE_END && tag_shift != TAG_WAVE) ||
                        (idx == IDX_FMT_END  && tag_shift != TAG_FMT))
                    begin
                        r    = status_result(ST_INVALID);
                        made = 1'b1;
                    end
                    else
                    begin
                        if (idx == IDX_FMT_LEN)  fmt_len  = tag_shift;
                        if (idx == IDX_FORMAT)   fmt_code = tag_shift[31:16];
                        if (idx == IDX_CHANNELS) channels = tag_shift[31:16];
                        if (idx == IDX_RATE)     rate     = tag_shift;
                        if (idx == IDX_BITS)
                        begin
                            bits = tag_shift[31:16];
                            if (fmt_code != FMT_PCM &&
                                !(fmt_code == FMT_FLOAT && bits == FLOAT_BITS))
                            begin
                                r    = status_result(ST_UNSUPPORTED);
                                made = 1'b1;
                            end
                            else
                            begin
                                byte_idx = '0;
                                if (fmt_len > FMT_BASE_LEN)
                                begin
                                    skip_left   = fmt_len - FMT_BASE_LEN;
                                    parse_phase = PH_FMT_SKIP;
                                end
                                else
                                    parse_phase = PH_CHUNK_HDR;
                            end
                        end
                    end
                end
                PH_FMT_SKIP, PH_CHUNK_SKIP:
                begin
                    skip_left = skip_left - 32'd1;
                    if (skip_left == 0)
                    begin
                        parse_phase = PH_CHUNK_HDR;
                        byte_idx    = '0;
                    end
                end
                PH_CHUNK_HDR:
                begin
                    idx      = byte_idx;
                    byte_idx = byte_idx + 6'd1;
                    if (idx < IDX_TAG_BYTES)
                        tag_shift = {it.in_byte, tag_shift[31:8]};
                    else
                    begin
                        chunk_len = {it.in_byte, chunk_len[31:8]};
                        if (idx == IDX_CHUNK_LAST)
                        begin
                            byte_idx = '0;
                            if (tag_shift == TAG_DATA)
                            begin
                                data_left   = chunk_len;
                                r           = status_result(ST_OPENED);
                                parse_phase = PH_DATA;
                                made        = 1'b1;
                            end
                            else if (chunk_len != 0)
                            begin
                                skip_left   = chunk_len;
                                parse_phase = PH_CHUNK_SKIP;
                            end
                        end
                    end
                end
                PH_DATA:
                begin
                    if (data_left == 0)
                        parse_phase = PH_IDLE;
                    else
                    begin
                        data_left   = data_left - 32'd1;
                        r.kind      = KIND_PCM;
                        r.pcm_byte  = it.in_byte;
                        r.last_data = (data_left == 0) || it.end_of_file;
                        if (data_left == 0)
                            parse_phase = PH_IDLE;
                        made = 1'b1;
                    end
                end
                default:
                    parse_phase = PH_IDLE;
            endcase
            // End of file before the data chunk opened is invalid
            if (it.end_of_file)
            begin
                if (!made && parse_phase != PH_IDLE && parse_phase != PH_DATA)
                begin
                    r    = status_result(ST_INVALID);
                    made = 1'b1;
                end
                parse_phase = PH_IDLE;
            end
            if (made)
                due_results.push_back(r);
        endfunction

        task report(string msg);
            error_count++;
            $display("ERROR: result %0d: %s", result_count, msg);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        endtask

        // Compare one result transaction against the oldest owed result
        task check_result(result_t got);
            result_t want;
            result_count++;
            if (due_results.size() == 0)
            begin
                report($sformatf("unexpected result kind %0d", got.kind));
                return;
            end
            want = due_results.pop_front();
            compare_field("kind",          32'(got.kind),          32'(want.kind));
            compare_field("pcm_byte",      32'(got.pcm_byte),      32'(want.pcm_byte));
            compare_field("status",        32'(got.status),        32'(want.status));
            compare_field("channel_count", 32'(got.channel_count), 32'(want.channel_count));
            compare_field("rate_hz",       got.rate_hz,            want.rate_hz);
            compare_field("sample_bits",   32'(got.sample_bits),   32'(want.sample_bits));
            compare_field("format_code",   32'(got.format_code),   32'(want.format_code));
            compare_field("data_length",   got.data_length,        want.data_length);
            compare_field("last_data",     32'(got.last_data),     32'(want.last_data));
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic [0:0]   s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tlast;

    wav_parse_scoreboard sb;
    logic [7:0]          wav_q[$];
    bit                  s_fire;
    bit                  m_fire;
    bit                  s_burst;
    bit                  m_burst;
    int unsigned         bytes_sent;
    int unsigned         idle_cycles;
    int unsigned         file_no;

    wav_stream_header_parser_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sample both sides, score transactions and watch for a hang
    always @(posedge clk)
    begin
        item_t   it;
        result_t got;
        s_fire = s_tvalid && s_tready;
        m_fire = m_tvalid && m_tready;
        if (rst_n && s_fire)
        begin
            it.in_byte     = s_tdata;
            it.first_byte  = s_tuser[0];
            it.end_of_file = s_tlast;
            sb.note_byte(it);
        end
        if (rst_n && m_fire)
        begin
            got.kind          = m_tuser[0];
            got.pcm_byte      = m_tdata[7:0];
            got.status        = status_t'(m_tdata[9:8]);
            got.channel_count = m_tdata[25:10];
            got.rate_hz       = m_tdata[57:26];
            got.sample_bits   = m_tdata[73:58];
            got.format_code   = m_tdata[89:74];
            got.data_length   = m_tdata[121:90];
            got.last_data     = m_tlast;
            sb.check_result(got);
        end
        if (rst_n)
        begin
            if (s_fire || m_fire)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no transaction for %0d cycles", idle_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Result side: stall a random number of cycles before each transaction
    initial
    begin
        int gap;
        m_tready = 1'b0;
        m_burst  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                m_burst = ~m_burst;
            gap = m_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(negedge clk); while (!m_fire);
        end
    end

    task automatic push8(logic [7:0] b);
        wav_q.push_back(b);
    endtask

    task automatic push16(logic [15:0] v);
        push8(v[7:0]);
        push8(v[15:8]);
    endtask

    task automatic push32(logic [31:0] v);
        push16(v[15:0]);
        push16(v[31:16]);
    endtask

    // Append the canonical 36-byte header
    task automatic put_header(logic [31:0] fmt_size, logic [15:0] fmt_v,
                              logic [15:0] chans, logic [31:0] srate, logic [15:0] bits_v);
        push32(TAG_RIFF);
        push32($urandom);
        push32(TAG_WAVE);
        push32(TAG_FMT);
        push32(fmt_size);
        push16(fmt_v);
        push16(chans);
        push32(srate);
        push32($urandom);
        push16(16'($urandom));
        push16(bits_v);
    endtask

    task automatic put_chunk(logic [31:0] tag, logic [31:0] len);
        push32(tag);
        push32(len);
    endtask

    task automatic put_data(int n);
        repeat (n) push8(8'($urandom));
    endtask

    // Drive one byte transaction after a random gap; call at a falling edge
    task automatic send_byte(item_t it);
        int gap;
        gap = s_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = it.in_byte;
        s_tuser  = it.first_byte;
        s_tlast  = it.end_of_file;
        do @(negedge clk); while (!s_fire);
        bytes_sent++;
    endtask

    // Stream the built file, marking its first and last bytes as asked
    task automatic send_file(bit first_mark, bit eof_mark);
        item_t it;
        s_burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < wav_q.size(); i++)
        begin
            it.in_byte     = wav_q[i];
            it.first_byte  = first_mark && (i == 0);
            it.end_of_file = eof_mark && (i == wav_q.size() - 1);
            send_byte(it);
        end
        wav_q.delete();
    endtask

    // Hold off the sender until every owed result has arrived
    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Mostly well-formed files with random content, some broken, some noise
    task automatic random_file();
        int          pick;
        int          dsend;
        int          cut;
        logic [15:0] fmt_v;
        logic [15:0] bits_v;
        logic [31:0] fmt_size;
        logic [31:0] dlen;
        logic [31:0] clen;
        item_t       it;
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            s_burst = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 40))
            begin
                it.in_byte     = 8'($urandom);
                it.first_byte  = ($urandom_range(0, 7) == 0);
                it.end_of_file = ($urandom_range(0, 15) == 0);
                send_byte(it);
            end
            return;
        end
        pick = $urandom_range(0, 9);
        if (pick < 7)
        begin
            fmt_v  = FMT_PCM;
            bits_v = 16'($urandom);
        end
        else if (pick == 7)
        begin
            fmt_v  = FMT_FLOAT;
            bits_v = FLOAT_BITS;
        end
        else if (pick == 8)
        begin
            fmt_v  = FMT_FLOAT;
            bits_v = 16'($urandom_range(0, 64));
        end
        else
        begin
            fmt_v  = 16'($urandom);
            bits_v = 16'($urandom);
        end
        pick = $urandom_range(0, 9);
        if (pick < 6)
            fmt_size = 16;
        else if (pick < 8)
            fmt_size = $urandom_range(17, 24);
        else
            fmt_size = $urandom_range(0, 15);
        put_header(fmt_size, fmt_v, 16'($urandom), $urandom, bits_v);
        if (fmt_size > 16)
            put_data(fmt_size - 16);
        // Occasionally overwrite one of the first 16 bytes, which may break a signature
        if ($urandom_range(0, 11) == 0)
            wav_q[$urandom_range(0, 15)] = 8'($urandom);
        repeat ($urandom_range(0, 2))
        begin
            clen = $urandom_range(0, 7);
            put_chunk(($urandom_range(0, 1) == 0) ? TAG_LIST : $urandom, clen);
            put_data(clen);
        end
        pick = $urandom_range(0, 9);
        if (pick < 8)
            dlen = $urandom_range(0, 24);
        else if (pick == 8)
            dlen = $urandom;
        else
            dlen = 1;
        put_chunk(TAG_DATA, dlen);
        dsend = (dlen > 32) ? $urandom_range(0, 16) : dlen;
        pick  = $urandom_range(0, 19);
        if (pick < 3)
            dsend = $urandom_range(0, dsend);
        else if (pick < 5)
            dsend = dsend + $urandom_range(1, 6);
        put_data(dsend);
        // Occasionally end the file anywhere
        if ($urandom_range(0, 12) == 0)
        begin
            cut   = $urandom_range(1, wav_q.size());
            wav_q = wav_q[0:cut-1];
        end
        send_file($urandom_range(0, 19) != 0, $urandom_range(0, 6) != 0);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        s_tlast     = 1'b0;
        s_burst     = 1'b0;
        bytes_sent  = 0;
        idle_cycles = 0;
        file_no     = 0;
        sb          = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Parse from reset without a first-byte marker
        put_header(16, FMT_PCM, 2, 44100, 16);
        put_chunk(TAG_DATA, 4);
        put_data(4);
        send_file(1'b0, 1'b1);

        // Bad RIFF, WAVE and fmt signatures; trailing bytes are ignored
        put_header(16, FMT_PCM, 1, 8000, 8);
        wav_q[3] = 8'h58;
        send_file(1'b1, 1'b1);
        put_header(16, FMT_PCM, 1, 8000, 8);
        wav_q[11] = 8'h00;
        send_file(1'b1, 1'b1);
        put_header(16, FMT_PCM, 1, 8000, 8);
        wav_q[15] = 8'hFF;
        send_file(1'b1, 1'b1);

        // Unsupported formats, including float with the wrong depth
        put_header(16, 16'd2, 1, 22050, 4);
        send_file(1'b1, 1'b1);
        put_header(16, FMT_FLOAT, 2, 48000, 16);
        send_file(1'b1, 1'b1);
        put_header(16, 16'd0, 16'd0, 32'd0, 16'd0);
        send_file(1'b1, 1'b1);

        // Float with extra fmt bytes, an odd chunk, an empty chunk, extreme values
        put_header(18, FMT_FLOAT, 16'hFFFF, 32'hFFFF_FFFF, FLOAT_BITS);
        push16(16'h0000);
        put_chunk(TAG_LIST, 3);
        put_data(3);
        put_chunk(TAG_JUNK, 0);
        put_chunk(TAG_DATA, 4);
        push8(8'h00);
        push8(8'hFF);
        push8(8'h55);
        push8(8'hAA);
        send_file(1'b1, 1'b1);

        // Truncated data: the end-of-file byte is the last one
        put_header(16, FMT_PCM, 16'hFFFF, 96000, 16'hFFFF);
        put_chunk(TAG_DATA, 32'hFFFF_FFFF);
        put_data(3);
        send_file(1'b1, 1'b1);

        // Zero-length data: later bytes are dropped
        put_header(16, FMT_PCM, 1, 11025, 8);
        put_chunk(TAG_DATA, 0);
        put_data(3);
        send_file(1'b1, 1'b1);

        // Data header completes on the last byte
        put_header(16, FMT_PCM, 1, 16000, 16);
        put_chunk(TAG_DATA, 8);
        send_file(1'b1, 1'b1);

        // End of file inside the header
        put_header(16, FMT_PCM, 1, 16000, 16);
        wav_q = wav_q[0:20];
        send_file(1'b1, 1'b1);

        // End of file exactly where an fmt skip runs out
        put_header(20, FMT_PCM, 1, 16000, 16);
        push32(32'h0);
        send_file(1'b1, 1'b1);

        // Surplus data bytes, then a restart in the middle of the data
        put_header(16, FMT_PCM, 2, 32000, 24);
        put_chunk(TAG_DATA, 2);
        put_data(5);
        send_file(1'b1, 1'b0);
        put_header(16, FMT_PCM, 2, 32000, 24);
        put_chunk(TAG_DATA, 10);
        put_data(3);
        send_file(1'b1, 1'b0);
        drain();

        while (bytes_sent < BYTE_TARGET)
        begin
            random_file();
            file_no++;
            if (file_no == 3 || $urandom_range(0, 9) == 0)
                drain();
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
